>>> rtl/ccirc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccirc_pkg: shared types and constants
// Fixed output width, the centre and radius limits, and the result word that
// the solver puts out.
// ----------------------------------------------------------------------------
package ccirc_pkg;

    localparam int OUT_BITS = 24;

    // centre and radius limits in the output format
    localparam logic signed [OUT_BITS-1:0] C_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] C_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0]        R_MAX = {OUT_BITS{1'b1}};

    // result word: one handshake moves one of these
    typedef struct packed {
        logic signed [OUT_BITS-1:0] center_x;
        logic signed [OUT_BITS-1:0] center_y;
        logic        [OUT_BITS-1:0] radius;
        logic                       degenerate;
        logic                       saturated;
    } t_result;

endpackage : ccirc_pkg
`default_nettype wire

>>> rtl/ccirc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccirc_front: bisector set-up and degenerate check
// Registered stages that form the Cramer determinant and the two numerators
// from one point triple, and flag collinear triples. Pipeline advances as a
// whole when its output stage is empty or the downstream queue has room.
// ----------------------------------------------------------------------------
module ccirc_front #(
    parameter int CW = 12,
    parameter int DW = 2*CW + 4,   // determinant width (signed)
    parameter int NW = 3*CW + 6    // numerator width (signed)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [CW-1:0]        i_ax,
    input  wire  [CW-1:0]        i_ay,
    input  wire  [CW-1:0]        i_bx,
    input  wire  [CW-1:0]        i_by,
    input  wire  [CW-1:0]        i_cx,
    input  wire  [CW-1:0]        i_cy,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [DW-1:0] o_det,
    output logic signed [NW-1:0] o_nx,
    output logic signed [NW-1:0] o_ny,
    output logic                 o_degen,
    output logic [CW-1:0]        o_ax,
    output logic [CW-1:0]        o_ay
);

    localparam int LW = CW + 2;      // a1, b1, a2, b2
    localparam int QW = 2*CW + 3;    // c1, c2

    logic adv;

    // stage 1: differences and squared-length differences
    logic                 r_v1;
    logic signed [LW-1:0] r_a1, r_b1, r_a2, r_b2;
    logic signed [QW-1:0] r_c1, r_c2;
    logic [CW-1:0]        r_ax1, r_ay1;

    // stage 2: products
    logic                 r_v2;
    logic signed [DW-1:0] r_p1, r_p2;
    logic signed [NW-1:0] r_p3, r_p4, r_p5, r_p6;
    logic [CW-1:0]        r_ax2, r_ay2;

    // stage 3: determinant and numerators
    logic                 r_v3;
    logic signed [DW-1:0] r_det;
    logic signed [NW-1:0] r_nx, r_ny;
    logic [CW-1:0]        r_ax3, r_ay3;

    logic signed [LW-1:0] n_a1, n_b1, n_a2, n_b2;
    logic signed [QW-1:0] n_c1, n_c2;
    logic [2*CW-1:0]      sa, sb, sc;

    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv;

    always_comb begin
        n_a1 = LW'(2) * (LW'({1'b0, i_bx}) - LW'({1'b0, i_ax}));
        n_b1 = LW'(2) * (LW'({1'b0, i_by}) - LW'({1'b0, i_ay}));
        n_a2 = LW'(2) * (LW'({1'b0, i_ax}) - LW'({1'b0, i_cx}));
        n_b2 = LW'(2) * (LW'({1'b0, i_ay}) - LW'({1'b0, i_cy}));
        sa   = (2*CW)'(i_ax) * (2*CW)'(i_ax);
        sb   = (2*CW)'(i_bx) * (2*CW)'(i_bx);
        sc   = (2*CW)'(i_cx) * (2*CW)'(i_cx);
        n_c1 = QW'(sb) + QW'((2*CW)'(i_by) * (2*CW)'(i_by))
             - QW'(sa) - QW'((2*CW)'(i_ay) * (2*CW)'(i_ay));
        n_c2 = QW'(sa) + QW'((2*CW)'(i_ay) * (2*CW)'(i_ay))
             - QW'(sc) - QW'((2*CW)'(i_cy) * (2*CW)'(i_cy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a1 <= n_a1; r_b1 <= n_b1; r_a2 <= n_a2; r_b2 <= n_b2;
            r_c1 <= n_c1; r_c2 <= n_c2;
            r_ax1 <= i_ax; r_ay1 <= i_ay;

            r_p1 <= DW'(r_a1) * DW'(r_b2);
            r_p2 <= DW'(r_a2) * DW'(r_b1);
            r_p3 <= NW'(r_c1) * NW'(r_b2);
            r_p4 <= NW'(r_c2) * NW'(r_b1);
            r_p5 <= NW'(r_a1) * NW'(r_c2);
            r_p6 <= NW'(r_a2) * NW'(r_c1);
            r_ax2 <= r_ax1; r_ay2 <= r_ay1;

            r_det <= r_p1 - r_p2;
            r_nx  <= r_p3 - r_p4;
            r_ny  <= r_p5 - r_p6;
            r_ax3 <= r_ax2; r_ay3 <= r_ay2;
        end
    end

    assign o_valid = r_v3;
    assign o_det   = r_det;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_degen = (r_det == '0);
    assign o_ax    = r_ax3;
    assign o_ay    = r_ay3;

`ifndef SYNTH
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_ready) |-> !o_ready)
        else $error("front accepted while its output stalled");
    a_v3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_ready) |=> (r_v3 && $stable(r_det)))
        else $error("front output changed while stalled");
    a_v_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v2) |=> r_v3)
        else $error("front stage valid lost");
`endif

endmodule : ccirc_front
`default_nettype wire

>>> rtl/ccirc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccirc_fifo: short queue between front end and solver
// Register-based FIFO; full and empty come from a count.
// ----------------------------------------------------------------------------
module ccirc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [W-1:0] i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");
`endif

endmodule : ccirc_fifo
`default_nettype wire

>>> rtl/ccirc_solve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccirc_solve: divide, square root, clamp
// Pipelined restoring divider (one quotient bit per stage), difference and
// square stages, pipelined rounded square root (one root bit per stage),
// then clamp into the output word. Whole pipe advances when the output
// register is free.
// ----------------------------------------------------------------------------
module ccirc_solve #(
    parameter int CW = 12,
    parameter int FB = 4,
    parameter int DW = 2*CW + 4,
    parameter int NW = 3*CW + 6
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  signed [DW-1:0] i_det,
    input  wire  signed [NW-1:0] i_nx,
    input  wire  signed [NW-1:0] i_ny,
    input  wire                  i_degen,
    input  wire  [CW-1:0]        i_ax,
    input  wire  [CW-1:0]        i_ay,
    output logic                 o_valid,
    input  wire                  i_ready,
    output ccirc_pkg::t_result   o_res
);

    localparam int OB  = ccirc_pkg::OUT_BITS;
    // dividend magnitude 2*|n|*2^FB + det, bounded by 2^(NW+FB)
    localparam int MW  = NW + FB + 1;
    localparam int QB  = MW;            // quotient bits (unsigned)
    localparam int EW  = DW + 1;        // divisor 2*det width
    localparam int RW  = EW + 1;        // partial remainder width
    localparam int QSW = QB + 1;        // signed quotient width
    localparam int SW  = 2*OB + 2;      // sum of squares width
    localparam int RTB = OB + 1;        // root bits
    localparam int DTW = CW + FB + 1;   // ax*scale width (unsigned)

    // ------------------------------------------------------------------
    // divider pipeline record
    typedef struct packed {
        logic            v;
        logic            degen;
        logic            negx, negy;
        logic [EW-1:0]   d2;
        logic [MW-1:0]   mx, my;
        logic [RW-1:0]   rx, ry;
        logic [QB-1:0]   qx, qy;
        logic [CW-1:0]   ax, ay;
    } t_div;

    typedef struct packed {
        logic            v;
        logic            degen;
        logic            sat;
        logic signed [QSW-1:0] qx, qy;
        logic [SW-1:0]   s;
        logic [SW-1:0]   rem;
        logic [RTB-1:0]  root;
    } t_sq;

    logic adv;
    logic r_ov;
    ccirc_pkg::t_result r_res;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    // ------------------------------------------------------------------
    // stage 0: sign fold and dividend set-up
    t_div n_d0;
    logic [DW-1:0] dabs;
    logic          dneg;
    logic signed [NW-1:0] fx, fy;
    always_comb begin
        dneg = i_det[DW-1];
        dabs = dneg ? DW'(-i_det) : DW'(i_det);
        fx   = dneg ? -i_nx : i_nx;
        fy   = dneg ? -i_ny : i_ny;
        n_d0       = '0;
        n_d0.v     = i_valid;
        n_d0.degen = i_degen;
        n_d0.negx  = fx[NW-1];
        n_d0.negy  = fy[NW-1];
        n_d0.d2    = {dabs, 1'b0};
        n_d0.mx    = (MW'(fx[NW-1] ? -fx : fx) << (FB + 1)) + MW'(dabs);
        n_d0.my    = (MW'(fy[NW-1] ? -fy : fy) << (FB + 1)) + MW'(dabs);
        n_d0.ax    = i_ax;
        n_d0.ay    = i_ay;
    end

    t_div r_d [QB+1];

    // one quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_d[k].v <= 1'b0;
            end
        end else if (adv) begin
            r_d[0] <= n_d0;
            for (int k = 1; k <= QB; k++) begin
                t_div          nd;
                logic [RW-1:0] tx, ty;
                nd    = r_d[k-1];
                tx    = {r_d[k-1].rx[RW-2:0], r_d[k-1].mx[MW-1]};
                ty    = {r_d[k-1].ry[RW-2:0], r_d[k-1].my[MW-1]};
                nd.mx = {r_d[k-1].mx[MW-2:0], 1'b0};
                nd.my = {r_d[k-1].my[MW-2:0], 1'b0};
                if (tx >= RW'(r_d[k-1].d2)) begin
                    nd.rx = tx - RW'(r_d[k-1].d2);
                    nd.qx = {r_d[k-1].qx[QB-2:0], 1'b1};
                end else begin
                    nd.rx = tx;
                    nd.qx = {r_d[k-1].qx[QB-2:0], 1'b0};
                end
                if (ty >= RW'(r_d[k-1].d2)) begin
                    nd.ry = ty - RW'(r_d[k-1].d2);
                    nd.qy = {r_d[k-1].qy[QB-2:0], 1'b1};
                end else begin
                    nd.ry = ty;
                    nd.qy = {r_d[k-1].qy[QB-2:0], 1'b0};
                end
                r_d[k] <= nd;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage D: signed quotient, distance from A
    logic                  r_e_v, r_e_degen;
    logic signed [QSW-1:0] r_e_qx, r_e_qy;
    logic signed [QSW+1:0] r_e_dx, r_e_dy;
    logic signed [QSW-1:0] e_qx, e_qy;
    logic signed [QSW+1:0] e_dx, e_dy;
    always_comb begin
        e_qx = r_d[QB].negx ? -QSW'(r_d[QB].qx) : QSW'(r_d[QB].qx);
        e_qy = r_d[QB].negy ? -QSW'(r_d[QB].qy) : QSW'(r_d[QB].qy);
        e_dx = (QSW+2)'(DTW'(r_d[QB].ax) << FB) - (QSW+2)'(e_qx);
        e_dy = (QSW+2)'(DTW'(r_d[QB].ay) << FB) - (QSW+2)'(e_qy);
    end

    // stage E: range check and squares
    logic                  r_f_v, r_f_degen, r_f_big;
    logic signed [QSW-1:0] r_f_qx, r_f_qy;
    logic [2*OB-1:0]       r_f_sx, r_f_sy;
    logic [OB-1:0]         ex_abs, ey_abs;
    logic                  e_big;
    always_comb begin
        e_big  = (r_e_dx > (QSW+2)'($signed({1'b0, ccirc_pkg::R_MAX})))
              || (r_e_dx < -(QSW+2)'($signed({1'b0, ccirc_pkg::R_MAX})))
              || (r_e_dy > (QSW+2)'($signed({1'b0, ccirc_pkg::R_MAX})))
              || (r_e_dy < -(QSW+2)'($signed({1'b0, ccirc_pkg::R_MAX})));
        ex_abs = OB'(r_e_dx[QSW+1] ? -r_e_dx : r_e_dx);
        ey_abs = OB'(r_e_dy[QSW+1] ? -r_e_dy : r_e_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= r_d[QB].v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_degen <= r_d[QB].degen;
            r_e_qx    <= e_qx;
            r_e_qy    <= e_qy;
            r_e_dx    <= e_dx;
            r_e_dy    <= e_dy;
            r_f_degen <= r_e_degen;
            r_f_big   <= e_big;
            r_f_qx    <= r_e_qx;
            r_f_qy    <= r_e_qy;
            r_f_sx    <= ex_abs * ex_abs;
            r_f_sy    <= ey_abs * ey_abs;
        end
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage, MSB first (digit recurrence)
    t_sq n_s0;
    always_comb begin
        n_s0       = '0;
        n_s0.v     = r_f_v;
        n_s0.degen = r_f_degen;
        n_s0.sat   = r_f_big;
        n_s0.qx    = r_f_qx;
        n_s0.qy    = r_f_qy;
        n_s0.s     = SW'(r_f_sx) + SW'(r_f_sy);
    end

    t_sq r_s [RTB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RTB; k++) begin
                r_s[k].v <= 1'b0;
            end
        end else if (adv) begin
            r_s[0] <= n_s0;
            for (int k = 1; k <= RTB; k++) begin
                t_sq           ns;
                logic [SW-1:0] rem2, trial;
                ns    = r_s[k-1];
                rem2  = {r_s[k-1].rem[SW-3:0], r_s[k-1].s[SW-1 -: 2]};
                trial = {{(SW-RTB-2){1'b0}}, r_s[k-1].root, 2'b01};
                ns.s  = {r_s[k-1].s[SW-3:0], 2'b00};
                if (rem2 >= trial) begin
                    ns.rem  = rem2 - trial;
                    ns.root = {r_s[k-1].root[RTB-2:0], 1'b1};
                end else begin
                    ns.rem  = rem2;
                    ns.root = {r_s[k-1].root[RTB-2:0], 1'b0};
                end
                r_s[k] <= ns;
            end
        end
    end

    // ------------------------------------------------------------------
    // final: round root, clamp, build result word
    ccirc_pkg::t_result n_res;
    logic [RTB:0] rq;
    logic         sat;
    always_comb begin
        // s > q*q + q  <=>  remainder (s - q*q) > q
        rq  = (r_s[RTB].rem > SW'(r_s[RTB].root))
            ? ((RTB+1)'(r_s[RTB].root) + 1'b1) : (RTB+1)'(r_s[RTB].root);
        sat = r_s[RTB].sat;
        n_res = '0;
        if (r_s[RTB].sat) begin
            n_res.radius = ccirc_pkg::R_MAX;
        end else if (rq > (RTB+1)'(ccirc_pkg::R_MAX)) begin
            n_res.radius = ccirc_pkg::R_MAX;
            sat = 1'b1;
        end else begin
            n_res.radius = OB'(rq);
        end
        if (r_s[RTB].qx > QSW'(ccirc_pkg::C_MAX)) begin
            n_res.center_x = ccirc_pkg::C_MAX; sat = 1'b1;
        end else if (r_s[RTB].qx < QSW'(ccirc_pkg::C_MIN)) begin
            n_res.center_x = ccirc_pkg::C_MIN; sat = 1'b1;
        end else begin
            n_res.center_x = OB'(r_s[RTB].qx);
        end
        if (r_s[RTB].qy > QSW'(ccirc_pkg::C_MAX)) begin
            n_res.center_y = ccirc_pkg::C_MAX; sat = 1'b1;
        end else if (r_s[RTB].qy < QSW'(ccirc_pkg::C_MIN)) begin
            n_res.center_y = ccirc_pkg::C_MIN; sat = 1'b1;
        end else begin
            n_res.center_y = OB'(r_s[RTB].qy);
        end
        n_res.saturated = sat;
        if (r_s[RTB].degen) begin
            n_res = '0;
            n_res.degenerate = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_s[RTB].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.degenerate) |-> (r_res.radius == '0 && !r_res.saturated))
        else $error("degenerate word carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_res)))
        else $error("result changed while stalled");
    a_radius_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.radius != ccirc_pkg::R_MAX && !r_res.degenerate
         && r_res.center_x != ccirc_pkg::C_MAX && r_res.center_x != ccirc_pkg::C_MIN
         && r_res.center_y != ccirc_pkg::C_MAX && r_res.center_y != ccirc_pkg::C_MIN)
        |-> !r_res.saturated)
        else $error("saturated flag without clamped field");
`endif

endmodule : ccirc_solve
`default_nettype wire

>>> rtl/circumcircle_from_three_points_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circumcircle_from_three_points_top: circle through three points
// Centre by Cramer's rule on the two perpendicular bisectors, rounded to
// nearest in fixed point; radius as rounded square root of the squared
// distance from the first point.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   points  | in        | i_valid / o_ready  | i_ax i_ay i_bx i_by_coord
//           |           |                    | i_cx_in i_cy_in
//   circle  | out       | o_valid / i_ready  | o_center_x o_center_y o_radius
//           |           |                    | o_degenerate o_saturated
//
// One word per cycle sustained while the output is not stalled. An accepted
// input word passes 3 front stages, the queue, NW+FRAC_BITS+2 divider stages
// (48 at the defaults), 2 distance stages, 26 root stages and the output
// register.
// Reset clears all valid bits and the queue count; there is no clearing pass.
// Front and solver stall independently; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module circumcircle_from_three_points_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [COORD_BITS-1:0] i_ax,
    input  wire  [COORD_BITS-1:0] i_ay,
    input  wire  [COORD_BITS-1:0] i_bx,
    input  wire  [COORD_BITS-1:0] i_by_coord,
    input  wire  [COORD_BITS-1:0] i_cx_in,
    input  wire  [COORD_BITS-1:0] i_cy_in,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic signed [23:0]    o_center_x,
    output logic signed [23:0]    o_center_y,
    output logic [23:0]           o_radius,
    output logic                  o_degenerate,
    output logic                  o_saturated
);

    localparam int DW = 2*COORD_BITS + 4;
    localparam int NW = 3*COORD_BITS + 6;
    localparam int QW = DW + 2*NW + 1 + 2*COORD_BITS;

    // front -> queue
    logic                 f_valid, f_ready, f_degen;
    logic signed [DW-1:0] f_det;
    logic signed [NW-1:0] f_nx, f_ny;
    logic [COORD_BITS-1:0] f_ax, f_ay;

    // queue -> solver
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;

    ccirc_pkg::t_result res;

    ccirc_front #(.CW(COORD_BITS), .DW(DW), .NW(NW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_bx    (i_bx),
        .i_by    (i_by_coord),
        .i_cx    (i_cx_in),
        .i_cy    (i_cy_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_det   (f_det),
        .o_nx    (f_nx),
        .o_ny    (f_ny),
        .o_degen (f_degen),
        .o_ax    (f_ax),
        .o_ay    (f_ay)
    );

    // hold a few words so the front keeps flowing when the solver stalls
    ccirc_fifo #(.W(QW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_det, f_nx, f_ny, f_degen, f_ax, f_ay}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    ccirc_solve #(.CW(COORD_BITS), .FB(FRAC_BITS), .DW(DW), .NW(NW)) u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_det   (q_data[QW-1 -: DW]),
        .i_nx    (q_data[QW-DW-1 -: NW]),
        .i_ny    (q_data[QW-DW-NW-1 -: NW]),
        .i_degen (q_data[2*COORD_BITS]),
        .i_ax    (q_data[2*COORD_BITS-1 -: COORD_BITS]),
        .i_ay    (q_data[COORD_BITS-1:0]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_center_x   = res.center_x;
    assign o_center_y   = res.center_y;
    assign o_radius     = res.radius;
    assign o_degenerate = res.degenerate;
    assign o_saturated  = res.saturated;

endmodule : circumcircle_from_three_points_top
`default_nettype wire
